// File: src/pfb_pkg.sv
// Shared types, operation codes and link command bytes for the page framebuffer.
// Used by every module of the framebuffer and by its checker.
package pfb_pkg;

  localparam int WIDTH_DEF  = 96;
  localparam int HEIGHT_DEF = 68;

  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_INVERT    = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_RENDER    = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_LINK = 1'b1;

  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h00;

  localparam logic [1:0] PHASE_PAGE = 2'd0;
  localparam logic [1:0] PHASE_HI   = 2'd1;
  localparam logic [1:0] PHASE_LO   = 2'd2;
  localparam logic [1:0] PHASE_DATA = 2'd3;

  typedef struct packed {
    logic       kind;
    logic       pixel_value;
    logic [7:0] link_byte;
    logic       is_data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       start;
    logic [3:0] first_pg;
    logic [3:0] last_pg;
    logic       tick;
  } rnd_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       cmd;
    logic [7:0] cmd_byte;
    logic       last;
  } rnd_sts_t;

endpackage

// File: src/page_framebuffer_with_lcd_streamer.sv
// Page framebuffer with a 9-bit display-link streamer; instantiates pfb_store
// and pfb_render, uses pfb_pkg.
//
// Items are taken one at a time. Write and invert of an on-panel pixel read
// the byte, then write it back to the frame memory; a command tick and an
// off-panel read go straight to the output step; an on-panel pixel read and a
// data tick first wait for the registered memory read. Every other item is
// finished in the idle state. A result goes to an output register, so the next
// beat can be accepted while it waits. After reset and after each accepted
// clear-and-render, the memory is zero-filled one byte per cycle over
// WIDTH*ceil(HEIGHT/8) bytes (864 at default size) with in_stall_o held high.
module page_framebuffer_with_lcd_streamer #(
  parameter int WIDTH  = pfb_pkg::WIDTH_DEF,
  parameter int HEIGHT = pfb_pkg::HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic [7:0] px_i,
  input  logic [7:0] py_i,
  input  logic       color_i,
  input  logic [3:0] first_page_i,
  input  logic [3:0] final_page_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic       pixel_value_o,
  output logic [7:0] link_byte_o,
  output logic       is_data_o,
  output logic       last_o
);
  import pfb_pkg::*;

  localparam int PAGES  = (HEIGHT + 7) / 8;
  localparam int DEPTH  = WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_RD, S_PUT} state_e;

  state_e            state_q, state_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [2:0]        bit_q, bit_d;
  logic              color_q, color_d;
  logic              inv_q, inv_d;
  logic              rd_pix_q, rd_pix_d;

  logic              accept;
  logic              in_bounds;
  logic [ADDR_W-1:0] idx;
  logic [7:0]        mask;
  logic              clr_busy;
  logic              clr_start;
  logic              we;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  rnd_ctl_t          rnd_ctl;
  rnd_sts_t          rnd_sts;
  logic [ADDR_W-1:0] rnd_addr;
  logic              out_free;

  assign in_stall_o = (state_q != S_IDLE) || clr_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_bounds  = (px_i < 8'(WIDTH)) && (py_i < 8'(HEIGHT));
  assign idx        = ADDR_W'(px_i) + ADDR_W'(py_i[7:3]) * ADDR_W'(WIDTH);
  assign mask       = 8'(1) << bit_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign we    = (state_q == S_RMW);
  assign wdata = inv_q   ? (rdata ^ mask) :
                 color_q ? (rdata | mask) : (rdata & ~mask);

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    color_d     = color_q;
    inv_d       = inv_q;
    rd_pix_d    = rd_pix_q;
    re          = 1'b0;
    raddr       = idx;
    clr_start   = 1'b0;
    rnd_ctl     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_WRITE, OP_INVERT: begin
              if (in_bounds) begin
                re      = 1'b1;
                addr_d  = idx;
                bit_d   = py_i[2:0];
                color_d = color_i;
                inv_d   = (op_i == OP_INVERT);
                state_d = S_RMW;
              end
            end
            OP_READ: begin
              res_d          = '0;
              res_d.kind     = KIND_READ;
              bit_d          = py_i[2:0];
              rd_pix_d       = 1'b1;
              re             = in_bounds;
              state_d        = in_bounds ? S_RD : S_PUT;
            end
            OP_CLEAR_ALL: begin
              if (!rnd_sts.busy) begin
                clr_start        = 1'b1;
                rnd_ctl.start    = 1'b1;
                rnd_ctl.first_pg = 4'h0;
                rnd_ctl.last_pg  = 4'(PAGES - 1);
              end
            end
            OP_RENDER: begin
              if (!rnd_sts.busy) begin
                rnd_ctl.start    = 1'b1;
                rnd_ctl.first_pg = first_page_i;
                rnd_ctl.last_pg  = final_page_i;
              end
            end
            OP_TICK: begin
              if (rnd_sts.busy) begin
                rnd_ctl.tick    = 1'b1;
                res_d           = '0;
                res_d.kind      = KIND_LINK;
                if (rnd_sts.cmd) begin
                  res_d.link_byte = rnd_sts.cmd_byte;
                  state_d         = S_PUT;
                end else begin
                  res_d.is_data = 1'b1;
                  res_d.last    = rnd_sts.last;
                  rd_pix_d      = 1'b0;
                  re            = 1'b1;
                  raddr         = rnd_addr;
                  state_d       = S_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        state_d = S_IDLE;
      end
      S_RD: begin
        if (rd_pix_q) begin
          res_d.pixel_value = |(rdata & mask);
        end else begin
          res_d.link_byte = rdata;
        end
        state_d = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    out_q    <= out_d;
    addr_q   <= addr_d;
    bit_q    <= bit_d;
    color_q  <= color_d;
    inv_q    <= inv_d;
    rd_pix_q <= rd_pix_d;
  end

  pfb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_start_i (clr_start),
    .clr_busy_o  (clr_busy),
    .we_i        (we),
    .waddr_i     (addr_q),
    .wdata_i     (wdata),
    .re_i        (re),
    .raddr_i     (raddr),
    .rdata_o     (rdata)
  );

  pfb_render #(
    .WIDTH  (WIDTH),
    .PAGES  (PAGES),
    .ADDR_W (ADDR_W)
  ) u_render (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rnd_ctl),
    .sts_o  (rnd_sts),
    .addr_o (rnd_addr)
  );

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign pixel_value_o = out_q.pixel_value;
  assign link_byte_o   = out_q.link_byte;
  assign is_data_o     = out_q.is_data;
  assign last_o        = out_q.last;

endmodule

// File: src/pfb_store.sv
// Frame byte memory: one write port, one registered read port, and the
// zero-fill sweep run after reset and on a clear request. Uses pfb_pkg.
module pfb_store #(
  parameter int DEPTH  = 864,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_start_i,
  output logic              clr_busy_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);
  import pfb_pkg::*;

  logic [7:0]        mem [DEPTH];
  logic [ADDR_W-1:0] clr_ptr_q, clr_ptr_d;
  logic              clr_busy_q, clr_busy_d;
  logic [7:0]        rdata_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_comb begin
    clr_ptr_d  = clr_ptr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_ptr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
        clr_ptr_d  = '0;
      end else begin
        clr_ptr_d = clr_ptr_q + 1'b1;
      end
    end else if (clr_start_i) begin
      clr_busy_d = 1'b1;
      clr_ptr_d  = '0;
    end
  end

  assign wr_en   = clr_busy_q | we_i;
  assign wr_addr = clr_busy_q ? clr_ptr_q : waddr_i;
  assign wr_data = clr_busy_q ? 8'h00 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_ptr_q  <= clr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign rdata_o    = rdata_q;

endmodule

// File: src/pfb_render.sv
// Render sequencer: page range check, three command words, then the byte
// pointer walked one data word per tick. Uses pfb_pkg.
module pfb_render #(
  parameter int WIDTH  = 96,
  parameter int PAGES  = 9,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfb_pkg::rnd_ctl_t ctl_i,
  output pfb_pkg::rnd_sts_t sts_o,
  output logic [ADDR_W-1:0] addr_o
);
  import pfb_pkg::*;

  localparam int PTR_W = $clog2(WIDTH * PAGES + 1);

  logic             busy_q, busy_d;
  logic [1:0]       phase_q, phase_d;
  logic [3:0]       page_q, page_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [PTR_W-1:0] end_q, end_d;
  logic             range_ok;
  logic             is_last;

  assign range_ok = ({1'b0, ctl_i.first_pg} < 5'(PAGES)) &&
                    ({1'b0, ctl_i.last_pg} < 5'(PAGES)) &&
                    (ctl_i.first_pg <= ctl_i.last_pg);
  assign is_last  = (ptr_q + 1'b1) >= end_q;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    page_d  = page_q;
    ptr_d   = ptr_q;
    end_d   = end_q;
    if (!busy_q) begin
      if (ctl_i.start && range_ok) begin
        busy_d  = 1'b1;
        phase_d = PHASE_PAGE;
        page_d  = ctl_i.first_pg;
        ptr_d   = PTR_W'(ctl_i.first_pg) * PTR_W'(WIDTH);
        end_d   = (PTR_W'(ctl_i.last_pg) + 1'b1) * PTR_W'(WIDTH);
      end
    end else if (ctl_i.tick) begin
      if (phase_q != PHASE_DATA) begin
        phase_d = phase_q + 1'b1;
      end else begin
        ptr_d = ptr_q + 1'b1;
        if (is_last) begin
          busy_d  = 1'b0;
          phase_d = PHASE_PAGE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PHASE_PAGE;
      page_q  <= '0;
      ptr_q   <= '0;
      end_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      page_q  <= page_d;
      ptr_q   <= ptr_d;
      end_q   <= end_d;
    end
  end

  always_comb begin
    sts_o.busy = busy_q;
    sts_o.cmd  = (phase_q != PHASE_DATA);
    sts_o.last = is_last;
    case (phase_q)
      PHASE_PAGE: sts_o.cmd_byte = CMD_PAGE | {4'h0, page_q};
      PHASE_HI:   sts_o.cmd_byte = CMD_COL_HI;
      default:    sts_o.cmd_byte = CMD_COL_LO;
    endcase
  end

  assign addr_o = ptr_q[ADDR_W-1:0];

endmodule

// File: src/pfb_checker.sv
// Port-level checks for the page framebuffer, bound to the top level.
// Uses pfb_pkg for result kind codes and command bytes.
module pfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       kind_o,
  input logic       pixel_value_o,
  input logic [7:0] link_byte_o,
  input logic       is_data_o,
  input logic       last_o
);
  import pfb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(pixel_value_o) && $stable(link_byte_o) && $stable(is_data_o) &&
    $stable(last_o))
    else $error("output beat changed while stalled");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o == KIND_LINK && is_data_o)
    else $error("last flag on a beat that is not a link data word");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_READ |->
    link_byte_o == 8'h00 && !is_data_o && !last_o)
    else $error("read answer carries link fields");

  a_cmd_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_LINK && !is_data_o |->
    !pixel_value_o && !last_o &&
    (link_byte_o[7:4] == 4'hB || link_byte_o == CMD_COL_HI ||
     link_byte_o == CMD_COL_LO))
    else $error("malformed command word");

endmodule

bind page_framebuffer_with_lcd_streamer pfb_checker u_pfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .pixel_value_o (pixel_value_o),
  .link_byte_o   (link_byte_o),
  .is_data_o     (is_data_o),
  .last_o        (last_o)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for page_framebuffer_with_lcd_streamer.
// Predicts pixel reads and display-link words from its own frame store copy.
// Depends on pfb_pkg and the framebuffer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;

  localparam int W           = WIDTH_DEF;
  localparam int H           = HEIGHT_DEF;
  localparam int PAGES       = (H + 7) / 8;
  localparam int STORE_BYTES = W * PAGES;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] op_i;
  logic [7:0] px_i;
  logic [7:0] py_i;
  logic       color_i;
  logic [3:0] first_page_i;
  logic [3:0] final_page_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic       pixel_value_o;
  logic [7:0] link_byte_o;
  logic       is_data_o;
  logic       last_o;

  page_framebuffer_with_lcd_streamer #(
    .WIDTH (W),
    .HEIGHT(H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .px_i         (px_i),
    .py_i         (py_i),
    .color_i      (color_i),
    .first_page_i (first_page_i),
    .final_page_i (final_page_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .pixel_value_o(pixel_value_o),
    .link_byte_o  (link_byte_o),
    .is_data_o    (is_data_o),
    .last_o       (last_o)
  );

  // predictor state
  logic [7:0]  pix_mem [0:STORE_BYTES-1];
  int unsigned scan_ptr;
  int unsigned scan_end;
  logic [1:0]  cmd_step;
  logic [3:0]  scan_page;
  bit          busy_render;

  res_t        due_words[$];
  res_t        due_word;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_ticket;
  int hold_served;
  int hold_left;
  int cycle_count;
  int fail_count;
  int beats_sent;
  int words_checked;
  int link_words;
  int read_answers;
  int renders_done;
  int full_clears;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_words.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_words.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h data %0d last %0d", kind_o,
               link_byte_o, is_data_o, last_o);
        fail_count++;
      end else begin
        due_word = due_words.pop_front();
        check_field("kind", due_word.kind, kind_o);
        check_field("pixel_value", due_word.pixel_value, pixel_value_o);
        check_field("link_byte", due_word.link_byte, link_byte_o);
        check_field("is_data", due_word.is_data, is_data_o);
        check_field("last", due_word.last, last_o);
        words_checked++;
        if (due_word.kind == KIND_LINK) link_words++;
        else read_answers++;
      end
    end
  end

  function automatic void begin_render(logic [3:0] fp, logic [3:0] lp);
    if (fp >= PAGES || lp >= PAGES || fp > lp) return;
    scan_page   = fp;
    scan_ptr    = fp * W;
    scan_end    = (lp + 1) * W;
    cmd_step    = PHASE_PAGE;
    busy_render = 1'b1;
  endfunction

  function automatic void predict_beat(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                       logic c, logic [3:0] fp, logic [3:0] lp);
    bit          on_screen;
    int unsigned addr;
    logic [7:0]  bitmask;
    res_t        word;
    on_screen = (x < W) && (y < H);
    addr      = on_screen ? x + (y >> 3) * W : 0;
    bitmask   = 8'd1 << y[2:0];
    word      = '0;
    case (op)
      OP_WRITE: begin
        if (on_screen) pix_mem[addr] = c ? (pix_mem[addr] | bitmask) : (pix_mem[addr] & ~bitmask);
      end
      OP_INVERT: begin
        if (on_screen) pix_mem[addr] = pix_mem[addr] ^ bitmask;
      end
      OP_READ: begin
        word.kind        = KIND_READ;
        word.pixel_value = on_screen ? |(pix_mem[addr] & bitmask) : 1'b0;
        due_words.push_back(word);
      end
      OP_CLEAR_ALL: begin
        if (!busy_render) begin
          foreach (pix_mem[i]) pix_mem[i] = 8'h00;
          full_clears++;
          begin_render(4'd0, 4'(PAGES - 1));
        end
      end
      OP_RENDER: begin
        if (!busy_render) begin_render(fp, lp);
      end
      OP_TICK: begin
        if (busy_render) begin
          word.kind = KIND_LINK;
          case (cmd_step)
            PHASE_PAGE: begin
              word.link_byte = CMD_PAGE | {4'h0, scan_page};
              cmd_step       = PHASE_HI;
            end
            PHASE_HI: begin
              word.link_byte = CMD_COL_HI;
              cmd_step       = PHASE_LO;
            end
            PHASE_LO: begin
              word.link_byte = CMD_COL_LO;
              cmd_step       = PHASE_DATA;
            end
            default: begin
              word.link_byte = pix_mem[scan_ptr];
              word.is_data   = 1'b1;
              word.last      = (scan_ptr + 1 >= scan_end);
              scan_ptr++;
              if (word.last) begin
                busy_render = 1'b0;
                cmd_step    = PHASE_PAGE;
                renders_done++;
              end
            end
          endcase
          due_words.push_back(word);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(logic [2:0] op, logic [7:0] x, logic [7:0] y, logic c,
                           logic [3:0] fp, logic [3:0] lp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    px_i         <= x;
    py_i         <= y;
    color_i      <= c;
    first_page_i <= fp;
    final_page_i <= lp;
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(op, x, y, c, fp, lp);
    beats_sent++;
  endtask

  function automatic logic [7:0] pick_coord(int lim);
    if ($urandom_range(99) < 85) return 8'($urandom_range(0, lim - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_pixel_access();
    send_beat(OP_WRITE, 8'd0, 8'd0, 1'b1, 4'd0, 4'd0);
    send_beat(OP_READ, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_WRITE, 8'(W - 1), 8'(H - 1), 1'b1, 4'd15, 4'd15);
    send_beat(OP_READ, 8'(W - 1), 8'(H - 1), 1'b0, 4'd0, 4'd0);
    send_beat(OP_INVERT, 8'(W - 1), 8'(H - 1), 1'b1, 4'd0, 4'd0);
    send_beat(OP_READ, 8'(W - 1), 8'(H - 1), 1'b1, 4'd0, 4'd0);
    send_beat(OP_WRITE, 8'(W), 8'd0, 1'b1, 4'd0, 4'd0);
    send_beat(OP_READ, 8'(W), 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_READ, 8'd255, 8'd255, 1'b1, 4'd15, 4'd15);
    send_beat(OP_WRITE, 8'd0, 8'(H), 1'b1, 4'd0, 4'd0);
    send_beat(OP_READ, 8'd0, 8'(H), 1'b0, 4'd0, 4'd0);
    send_beat(OP_WRITE, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_READ, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
  endtask

  task automatic test_ignored_requests();
    send_beat(OP_RENDER, 8'd0, 8'd0, 1'b0, 4'd3, 4'd2);
    send_beat(OP_RENDER, 8'd0, 8'd0, 1'b0, 4'd0, 4'(PAGES));
    send_beat(OP_RENDER, 8'd0, 8'd0, 1'b0, 4'd15, 4'd15);
    send_beat(OP_TICK, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_SPARE_LO, 8'd1, 8'd1, 1'b1, 4'd0, 4'd0);
    send_beat(OP_SPARE_HI, 8'd1, 8'd1, 1'b1, 4'd0, 4'd0);
  endtask

  task automatic test_render_during_edits();
    send_beat(OP_RENDER, 8'd0, 8'd0, 1'b0, 4'(PAGES - 1), 4'(PAGES - 1));
    repeat (3) send_beat(OP_TICK, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_WRITE, 8'd0, 8'((PAGES - 1) * 8), 1'b1, 4'd0, 4'd0);
    send_beat(OP_TICK, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_RENDER, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_CLEAR_ALL, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_READ, 8'd0, 8'((PAGES - 1) * 8), 1'b0, 4'd0, 4'd0);
  endtask

  task automatic test_random_mix(int count);
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic       c;
    logic [3:0] fp;
    logic [3:0] lp;
    int         pick;
    repeat (count) begin
      x    = pick_coord(W);
      y    = pick_coord(H);
      c    = 1'($urandom_range(0, 1));
      fp   = 4'($urandom_range(0, 15));
      lp   = 4'($urandom_range(0, 15));
      pick = $urandom_range(99);
      if (busy_render) begin
        if (pick < 55) op = OP_TICK;
        else if (pick < 65) op = OP_WRITE;
        else if (pick < 72) op = OP_INVERT;
        else if (pick < 82) op = OP_READ;
        else if (pick < 90) op = OP_RENDER;
        else if (pick < 94) op = OP_CLEAR_ALL;
        else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
        if (pick < 30) op = OP_WRITE;
        else if (pick < 45) op = OP_INVERT;
        else if (pick < 65) op = OP_READ;
        else if (pick < 82) op = OP_RENDER;
        else if (pick < 92) op = OP_TICK;
        else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end
      if (op == OP_RENDER && $urandom_range(99) < 85) begin
        fp = 4'($urandom_range(0, PAGES - 1));
        lp = (fp < PAGES - 1 && $urandom_range(0, 3) == 0) ? fp + 4'd1 : fp;
      end
      send_beat(op, x, y, c, fp, lp);
    end
  endtask

  task automatic test_full_frame();
    logic [2:0] op;
    int         pick;
    while (busy_render) send_beat(OP_TICK, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    send_beat(OP_CLEAR_ALL, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0);
    while (busy_render) begin
      pick = $urandom_range(99);
      if (pick < 85) op = OP_TICK;
      else if (pick < 90) op = OP_WRITE;
      else if (pick < 95) op = OP_READ;
      else if (pick < 97) op = OP_RENDER;
      else op = OP_INVERT;
      send_beat(op, pick_coord(W), pick_coord(H), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_output_backpressure();
    hold_ticket++;
    repeat (24) begin
      send_beat(OP_READ, pick_coord(W), pick_coord(H), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_WRITE;
    px_i          = 8'd0;
    py_i          = 8'd0;
    color_i       = 1'b0;
    first_page_i  = 4'd0;
    final_page_i  = 4'd0;
    out_stall_i   = 1'b0;
    hold_ticket   = 0;
    hold_served   = 0;
    hold_left     = 0;
    cycle_count   = 0;
    fail_count    = 0;
    beats_sent    = 0;
    words_checked = 0;
    link_words    = 0;
    read_answers  = 0;
    renders_done  = 0;
    full_clears   = 0;
    foreach (pix_mem[i]) pix_mem[i] = 8'h00;
    scan_ptr      = 0;
    scan_end      = 0;
    cmd_step      = PHASE_PAGE;
    scan_page     = 4'd0;
    busy_render   = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 82;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_pixel_access();
    test_ignored_requests();
    test_render_during_edits();
    test_random_mix(150);

    send_idle_pct = 82;
    recv_idle_pct = 13;
    test_random_mix(200);
    test_full_frame();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(150);
    test_output_backpressure();

    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d beats sent, %0d results checked (%0d link words, %0d pixel reads)",
             beats_sent, words_checked, link_words, read_answers);
    $display("%0d renders streamed to the last word, %0d full-frame clears, %0d failures",
             renders_done, full_clears, fail_count);
    if (fail_count == 0 && due_words.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
